@@ rtl/core/ssi_pkg.sv @@
// shared types and constants for the segment intersection pipeline
`default_nettype none
package ssi_pkg;

    localparam int COORD_WIDTH = 16;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CROSS = 2'd1,
        KIND_MID   = 2'd2
    } t_kind;

    typedef struct packed {
        logic par_dirs;
        logic same_line;
    } t_pair_flags;

endpackage
`default_nettype wire

@@ rtl/core/segment_segment_intersection.sv @@
// top level of the segment-segment intersection pipeline
// usage:
//   slave channel: one transaction carries both segments, eight coordinates
//   packed in tdata. master channel: one transaction per input, the kind of
//   hit in tuser (none, crossing, collinear midpoint) and the point in tdata.
//   pipeline from acceptance to the output register: 4 front stages,
//   5 numerator stages, one divider stage per quotient bit, one box
//   test stage.
//   throughput: one transaction per cycle; a new pair is taken every cycle
//   that the output register is empty or being drained.
//   the whole pipeline advances together; when the receiver stalls with a
//   result waiting, every stage holds and tready drops in the same cycle.
//   reset clears every valid bit; no result is presented after reset until
//   a new input has travelled the full pipeline.
//   no-hit results carry a zero point.
`default_nettype none
module segment_segment_intersection #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [8*COORD_WIDTH-1:0]             i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // point_x, point_y, zero padding
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   o_m_tdata,
    // result_kind
    output ssi_pkg::t_kind                       o_m_tuser
);
    import ssi_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int D   = W + 1;
    localparam int DW  = 2 * W + 3;
    localparam int NW  = 3 * W + 3;
    localparam int QW  = W + 1;
    localparam int L   = W + 11;
    localparam int CL  = W + 10;
    localparam int FL  = W + 6;
    localparam int OTW = ((2 * W + 7) / 8) * 8;

    function automatic logic in_range(input logic signed [QW:0]  v,
                                      input logic signed [W-1:0] e1,
                                      input logic signed [W-1:0] e2);
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        lo = (e1 < e2) ? e1 : e2;
        hi = (e1 < e2) ? e2 : e1;
        return (v >= (QW+1)'(lo)) && (v <= (QW+1)'(hi));
    endfunction

    logic                ce;
    logic [L-1:0]        r_vld;
    logic signed [W-1:0] in_c [8];

    t_pair_flags          f_flags;
    logic signed [W-1:0]  f_ax1, f_ay1, f_mx, f_my;
    logic signed [D-1:0]  f_dax, f_day;
    logic signed [DW-1:0] f_den, f_tn;

    logic [NW-1:0]        nx_mag, ny_mag;
    logic                 nx_neg, ny_neg, nx_ovf, ny_ovf;
    logic signed [DW-1:0] nx_den, ny_den;

    logic [QW-1:0]        qx, qy;
    logic                 qx_neg, qy_neg, qx_ovf, qy_ovf;

    logic [8*W-1:0]       r_cd  [CL];
    t_pair_flags          r_fd  [FL];
    logic signed [W-1:0]  r_mxd [FL];
    logic signed [W-1:0]  r_myd [FL];

    logic signed [W-1:0]  ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [QW:0]   cx, cy;
    logic                 hit;
    t_pair_flags          e_flags;
    t_kind                n_kind, r_kind;
    logic signed [W-1:0]  n_px, n_py, r_px, r_py;

    assign ce         = !r_vld[L-1] || i_m_tready;
    assign o_s_tready = ce;
    assign o_m_tvalid = r_vld[L-1];

    for (genvar k = 0; k < 8; k++) begin : g_unpack
        assign in_c[k] = $signed(i_s_tdata[k*W +: W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[L-2:0], i_s_tvalid};
        end
    end

    ssi_front #(.COORD_WIDTH(W)) u_front (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_ax1   (in_c[0]),
        .i_ay1   (in_c[1]),
        .i_ax2   (in_c[2]),
        .i_ay2   (in_c[3]),
        .i_bx1   (in_c[4]),
        .i_by1   (in_c[5]),
        .i_bx2   (in_c[6]),
        .i_by2   (in_c[7]),
        .o_flags (f_flags),
        .o_ax1   (f_ax1),
        .o_ay1   (f_ay1),
        .o_dax   (f_dax),
        .o_day   (f_day),
        .o_mid_x (f_mx),
        .o_mid_y (f_my),
        .o_den   (f_den),
        .o_tn    (f_tn)
    );

    ssi_num #(.COORD_WIDTH(W)) u_num_x (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_base (f_ax1),
        .i_dir  (f_dax),
        .i_den  (f_den),
        .i_tn   (f_tn),
        .o_mag  (nx_mag),
        .o_neg  (nx_neg),
        .o_ovf  (nx_ovf),
        .o_den  (nx_den)
    );

    ssi_num #(.COORD_WIDTH(W)) u_num_y (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_base (f_ay1),
        .i_dir  (f_day),
        .i_den  (f_den),
        .i_tn   (f_tn),
        .o_mag  (ny_mag),
        .o_neg  (ny_neg),
        .o_ovf  (ny_ovf),
        .o_den  (ny_den)
    );

    ssi_div #(.COORD_WIDTH(W)) u_div_x (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_mag (nx_mag),
        .i_den (nx_den),
        .i_neg (nx_neg),
        .i_ovf (nx_ovf),
        .o_q   (qx),
        .o_neg (qx_neg),
        .o_ovf (qx_ovf)
    );

    ssi_div #(.COORD_WIDTH(W)) u_div_y (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_mag (ny_mag),
        .i_den (ny_den),
        .i_neg (ny_neg),
        .i_ovf (ny_ovf),
        .o_q   (qy),
        .o_neg (qy_neg),
        .o_ovf (qy_ovf)
    );

    // side data travelling alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cd[0] <= i_s_tdata;
            for (int k = 1; k < CL; k++) begin
                r_cd[k] <= r_cd[k-1];
            end
            r_fd[0]  <= f_flags;
            r_mxd[0] <= f_mx;
            r_myd[0] <= f_my;
            for (int k = 1; k < FL; k++) begin
                r_fd[k]  <= r_fd[k-1];
                r_mxd[k] <= r_mxd[k-1];
                r_myd[k] <= r_myd[k-1];
            end
        end
    end

    assign ax1 = $signed(r_cd[CL-1][0*W +: W]);
    assign ay1 = $signed(r_cd[CL-1][1*W +: W]);
    assign ax2 = $signed(r_cd[CL-1][2*W +: W]);
    assign ay2 = $signed(r_cd[CL-1][3*W +: W]);
    assign bx1 = $signed(r_cd[CL-1][4*W +: W]);
    assign by1 = $signed(r_cd[CL-1][5*W +: W]);
    assign bx2 = $signed(r_cd[CL-1][6*W +: W]);
    assign by2 = $signed(r_cd[CL-1][7*W +: W]);

    assign cx = qx_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign cy = qy_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    assign hit = !qx_ovf && !qy_ovf &&
                 in_range(cx, ax1, ax2) && in_range(cy, ay1, ay2) &&
                 in_range(cx, bx1, bx2) && in_range(cy, by1, by2);

    assign e_flags = r_fd[FL-1];

    always_comb begin
        n_kind = KIND_NONE;
        n_px   = '0;
        n_py   = '0;
        if (e_flags.par_dirs) begin
            if (e_flags.same_line) begin
                n_kind = KIND_MID;
                n_px   = r_mxd[FL-1];
                n_py   = r_myd[FL-1];
            end
        end else if (hit) begin
            n_kind = KIND_CROSS;
            n_px   = cx[W-1:0];
            n_py   = cy[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_kind <= n_kind;
            r_px   <= n_px;
            r_py   <= n_py;
        end
    end

    assign o_m_tdata = OTW'({r_py, r_px});
    assign o_m_tuser = r_kind;

`ifndef NO_ASSERTIONS
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_NONE) |-> (o_m_tdata == '0))
        else $error("no-hit result with a non-zero point");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result presented straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_vld))
        else $error("pipeline moved while the receiver stalled");
`endif

endmodule
`default_nettype wire

@@ rtl/core/ssi_front.sv @@
// front stages: directions, cross products, squared lengths, midpoints
`default_nettype none
module ssi_front #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic signed [COORD_WIDTH-1:0] i_ax1,
    input  logic signed [COORD_WIDTH-1:0] i_ay1,
    input  logic signed [COORD_WIDTH-1:0] i_ax2,
    input  logic signed [COORD_WIDTH-1:0] i_ay2,
    input  logic signed [COORD_WIDTH-1:0] i_bx1,
    input  logic signed [COORD_WIDTH-1:0] i_by1,
    input  logic signed [COORD_WIDTH-1:0] i_bx2,
    input  logic signed [COORD_WIDTH-1:0] i_by2,
    output ssi_pkg::t_pair_flags          o_flags,
    output logic signed [COORD_WIDTH-1:0] o_ax1,
    output logic signed [COORD_WIDTH-1:0] o_ay1,
    output logic signed [COORD_WIDTH:0]   o_dax,
    output logic signed [COORD_WIDTH:0]   o_day,
    output logic signed [COORD_WIDTH-1:0] o_mid_x,
    output logic signed [COORD_WIDTH-1:0] o_mid_y,
    output logic signed [2*COORD_WIDTH+2:0] o_den,
    output logic signed [2*COORD_WIDTH+2:0] o_tn
);
    import ssi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int D  = W + 1;
    localparam int P  = 2 * W + 2;
    localparam int DW = 2 * W + 3;

    function automatic logic signed [W-1:0] half_sum(input logic signed [W-1:0] p,
                                                     input logic signed [W-1:0] q);
        logic signed [D-1:0] s;
        logic signed [D-1:0] t;
        s = D'(p) + D'(q);
        t = s + $signed({{W{1'b0}}, s[D-1]});
        return t[D-1:1];
    endfunction

    // stage 1
    logic signed [D-1:0] r1_dax, r1_day, r1_dbx, r1_dby, r1_ox, r1_oy;
    logic signed [W-1:0] r1_ax1, r1_ay1, r1_mxa, r1_mya, r1_mxb, r1_myb;
    // stage 2
    logic signed [P-1:0] r2_den1, r2_den2, r2_ca1, r2_ca2, r2_cb1, r2_cb2;
    logic signed [P-1:0] r2_sax, r2_say, r2_sbx, r2_sby;
    logic signed [D-1:0] r2_dax, r2_day;
    logic signed [W-1:0] r2_ax1, r2_ay1, r2_mxa, r2_mya, r2_mxb, r2_myb;
    // stage 3
    logic signed [DW-1:0] r3_den, r3_ca, r3_cb, r3_la, r3_lb;
    logic signed [D-1:0]  r3_dax, r3_day;
    logic signed [W-1:0]  r3_ax1, r3_ay1, r3_mxa, r3_mya, r3_mxb, r3_myb;
    // stage 4
    t_pair_flags          r4_flags;
    logic signed [DW-1:0] r4_den, r4_tn;
    logic signed [D-1:0]  r4_dax, r4_day;
    logic signed [W-1:0]  r4_ax1, r4_ay1, r4_mx, r4_my;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_dax <= D'(i_ax2) - D'(i_ax1);
            r1_day <= D'(i_ay2) - D'(i_ay1);
            r1_dbx <= D'(i_bx2) - D'(i_bx1);
            r1_dby <= D'(i_by2) - D'(i_by1);
            r1_ox  <= D'(i_bx1) - D'(i_ax1);
            r1_oy  <= D'(i_by1) - D'(i_ay1);
            r1_ax1 <= i_ax1;
            r1_ay1 <= i_ay1;
            r1_mxa <= half_sum(i_ax1, i_ax2);
            r1_mya <= half_sum(i_ay1, i_ay2);
            r1_mxb <= half_sum(i_bx1, i_bx2);
            r1_myb <= half_sum(i_by1, i_by2);

            r2_den1 <= r1_dax * r1_dby;
            r2_den2 <= r1_day * r1_dbx;
            r2_ca1  <= r1_dax * r1_oy;
            r2_ca2  <= r1_day * r1_ox;
            r2_cb1  <= r1_dbx * r1_oy;
            r2_cb2  <= r1_dby * r1_ox;
            r2_sax  <= r1_dax * r1_dax;
            r2_say  <= r1_day * r1_day;
            r2_sbx  <= r1_dbx * r1_dbx;
            r2_sby  <= r1_dby * r1_dby;
            r2_dax  <= r1_dax;
            r2_day  <= r1_day;
            r2_ax1  <= r1_ax1;
            r2_ay1  <= r1_ay1;
            r2_mxa  <= r1_mxa;
            r2_mya  <= r1_mya;
            r2_mxb  <= r1_mxb;
            r2_myb  <= r1_myb;

            r3_den <= DW'(r2_den1) - DW'(r2_den2);
            r3_ca  <= DW'(r2_ca1) - DW'(r2_ca2);
            r3_cb  <= DW'(r2_cb1) - DW'(r2_cb2);
            r3_la  <= DW'(r2_sax) + DW'(r2_say);
            r3_lb  <= DW'(r2_sbx) + DW'(r2_sby);
            r3_dax <= r2_dax;
            r3_day <= r2_day;
            r3_ax1 <= r2_ax1;
            r3_ay1 <= r2_ay1;
            r3_mxa <= r2_mxa;
            r3_mya <= r2_mya;
            r3_mxb <= r2_mxb;
            r3_myb <= r2_myb;

            r4_flags.par_dirs  <= (r3_den == '0);
            r4_flags.same_line <= (r3_ca == '0) && (r3_cb == '0);
            // sign-normalised denominator, crossing parameter numerator follows
            r4_den <= r3_den[DW-1] ? -r3_den : r3_den;
            r4_tn  <= r3_den[DW-1] ? r3_cb : -r3_cb;
            r4_mx  <= (r3_la <= r3_lb) ? r3_mxa : r3_mxb;
            r4_my  <= (r3_la <= r3_lb) ? r3_mya : r3_myb;
            r4_dax <= r3_dax;
            r4_day <= r3_day;
            r4_ax1 <= r3_ax1;
            r4_ay1 <= r3_ay1;
        end
    end

    assign o_flags = r4_flags;
    assign o_den   = r4_den;
    assign o_tn    = r4_tn;
    assign o_mid_x = r4_mx;
    assign o_mid_y = r4_my;
    assign o_dax   = r4_dax;
    assign o_day   = r4_day;
    assign o_ax1   = r4_ax1;
    assign o_ay1   = r4_ay1;

endmodule
`default_nettype wire

@@ rtl/core/ssi_num.sv @@
// numerator stages: split products, sum, magnitude and range check
`default_nettype none
module ssi_num #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_ce,
    input  logic signed [COORD_WIDTH-1:0]   i_base,
    input  logic signed [COORD_WIDTH:0]     i_dir,
    input  logic signed [2*COORD_WIDTH+2:0] i_den,
    input  logic signed [2*COORD_WIDTH+2:0] i_tn,
    output logic [3*COORD_WIDTH+2:0]        o_mag,
    output logic                            o_neg,
    output logic                            o_ovf,
    output logic signed [2*COORD_WIDTH+2:0] o_den
);
    import ssi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int D  = W + 1;
    localparam int DW = 2 * W + 3;
    localparam int NW = 3 * W + 3;
    localparam int H  = (DW + 1) / 2;
    localparam int HW = DW - H;

    logic signed [H:0]    den_lo, tn_lo;
    logic signed [HW-1:0] den_hi, tn_hi;

    logic signed [W+H:0]    r1_pbl;
    logic signed [W+HW-1:0] r1_pbh;
    logic signed [D+H:0]    r1_pdl;
    logic signed [D+HW-1:0] r1_pdh;
    logic signed [DW-1:0]   r1_den, r2_den, r3_den, r4_den, r5_den;
    logic signed [NW-1:0]   r2_nb, r2_nd, r3_n;
    logic [NW-1:0]          r4_mag, r5_mag;
    logic                   r4_neg, r5_neg, r5_ovf;

    assign den_lo = $signed({1'b0, i_den[H-1:0]});
    assign den_hi = $signed(i_den[DW-1:H]);
    assign tn_lo  = $signed({1'b0, i_tn[H-1:0]});
    assign tn_hi  = $signed(i_tn[DW-1:H]);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_pbl <= i_base * den_lo;
            r1_pbh <= i_base * den_hi;
            r1_pdl <= i_dir * tn_lo;
            r1_pdh <= i_dir * tn_hi;
            r1_den <= i_den;

            r2_nb  <= (NW'(r1_pbh) <<< H) + NW'(r1_pbl);
            r2_nd  <= (NW'(r1_pdh) <<< H) + NW'(r1_pdl);
            r2_den <= r1_den;

            r3_n   <= r2_nb + r2_nd;
            r3_den <= r2_den;

            r4_neg <= r3_n[NW-1];
            r4_mag <= r3_n[NW-1] ? $unsigned(-r3_n) : $unsigned(r3_n);
            r4_den <= r3_den;

            // quotient would reach twice the coordinate range
            r5_ovf <= r4_mag >= (NW'($unsigned(r4_den)) << (W + 1));
            r5_mag <= r4_mag;
            r5_neg <= r4_neg;
            r5_den <= r4_den;
        end
    end

    assign o_mag = r5_mag;
    assign o_neg = r5_neg;
    assign o_ovf = r5_ovf;
    assign o_den = r5_den;

endmodule
`default_nettype wire

@@ rtl/core/ssi_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module ssi_div #(
    parameter int COORD_WIDTH = ssi_pkg::COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_ce,
    input  logic [3*COORD_WIDTH+2:0]        i_mag,
    input  logic signed [2*COORD_WIDTH+2:0] i_den,
    input  logic                            i_neg,
    input  logic                            i_ovf,
    output logic [COORD_WIDTH:0]            o_q,
    output logic                            o_neg,
    output logic                            o_ovf
);
    import ssi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 3;
    localparam int NW = 3 * W + 3;
    localparam int S  = W + 1;
    localparam int QW = W + 1;

    logic [NW-1:0] r_rem [S];
    logic [DW-1:0] r_den [S];
    logic [QW-1:0] r_q   [S];
    logic          r_neg [S];
    logic          r_ovf [S];

    for (genvar j = 0; j < S; j++) begin : g_stage
        localparam int SH = W - j;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic          neg_in, ovf_in;
        logic [NW:0]   trial;

        if (j == 0) begin : g_first
            assign rem_in = i_mag;
            assign den_in = $unsigned(i_den);
            assign q_in   = '0;
            assign neg_in = i_neg;
            assign ovf_in = i_ovf;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign q_in   = r_q[j-1];
            assign neg_in = r_neg[j-1];
            assign ovf_in = r_ovf[j-1];
        end

        assign trial = {1'b0, rem_in} - ((NW+1)'(den_in) << SH);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j] <= trial[NW] ? rem_in : trial[NW-1:0];
                r_q[j]   <= q_in | (QW'(!trial[NW]) << SH);
                r_den[j] <= den_in;
                r_neg[j] <= neg_in;
                r_ovf[j] <= ovf_in;
            end
        end
    end

    assign o_q   = r_q[S-1];
    assign o_neg = r_neg[S-1];
    assign o_ovf = r_ovf[S-1];

endmodule
`default_nettype wire
